/* design/cmss_pkg.sv */
// ----------------------------------------------------------------------------
// cmss_pkg
// Shared types and constants for the cell monitor service sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package cmss_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 32;

  localparam logic [31:0] MeasurePeriodRst  = 32'd100;
  localparam logic [15:0] IdleTimeoutRst    = 16'd5;
  localparam logic [15:0] SleepTimeoutRst   = 16'd2000;
  localparam logic [7:0]  ConversionTimeRst = 8'd8;

  typedef enum logic [3:0] {
    SVC_BOOT    = 4'd0,
    SVC_WAKE    = 4'd1,
    SVC_CONFIG  = 4'd2,
    SVC_STANDBY = 4'd3,
    SVC_START   = 4'd4,
    SVC_WAIT    = 4'd5,
    SVC_READ    = 4'd6,
    SVC_PROCESS = 4'd7,
    SVC_FAULT   = 4'd8
  } svc_state_e;

  typedef enum logic [2:0] {
    LINK_OFF   = 3'd0,
    LINK_IDLE  = 3'd1,
    LINK_READY = 3'd2,
    LINK_XFER  = 3'd3,
    LINK_ERROR = 3'd4
  } link_state_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_WAKE   = 3'd1,
    ACT_CONFIG = 3'd2,
    ACT_START  = 3'd3,
    ACT_READ   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    RES_OK   = 2'd0,
    RES_FAIL = 2'd1,
    RES_LINK = 2'd2,
    RES_CRC  = 2'd3
  } action_result_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_COMM_ERR  = 2'd1,
    STAT_STATE_ERR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_MEASURE_PERIOD  = 2'd0,
    REG_IDLE_TIMEOUT    = 2'd1,
    REG_SLEEP_TIMEOUT   = 2'd2,
    REG_CONVERSION_TIME = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] measure_period;
    logic [15:0] idle_timeout;
    logic [15:0] sleep_timeout;
    logic [7:0]  conversion_time;
  } cfg_t;

  typedef struct packed {
    svc_state_e         svc;
    link_state_e        link;
    logic               configured;
    logic [TimeW-1:0]   last_comm;
    logic [TimeW-1:0]   last_measure;
    logic [TimeW-1:0]   entry;
    logic [CountW-1:0]  comm_errors;
    logic [CountW-1:0]  crc_errors;
    logic [CountW-1:0]  measurements;
  } seq_state_t;

endpackage

`default_nettype wire

/* design/cmss_step.sv */
// ----------------------------------------------------------------------------
// cmss_step
// Next-state logic for one service tick of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cmss_step (
  input  cmss_pkg::cfg_t           cfg_i,
  input  cmss_pkg::seq_state_t     cur_i,
  input  logic [31:0]              now_ms_i,
  input  logic [1:0]               action_result_i,
  output cmss_pkg::seq_state_t     nxt_o,
  output cmss_pkg::action_e        action_o,
  output cmss_pkg::status_e        status_o
);
  import cmss_pkg::*;

  logic [TimeW-1:0] since_comm;
  logic [TimeW-1:0] since_meas;
  logic [TimeW-1:0] since_entry;
  logic             idle_hit;
  logic             sleep_hit;
  logic             res_ok;
  logic [1:0]       comm_inc;
  logic             crc_inc;
  logic             meas_inc;
  seq_state_t       nxt;

  assign since_comm  = now_ms_i - cur_i.last_comm;
  assign since_meas  = now_ms_i - cur_i.last_measure;
  assign since_entry = now_ms_i - cur_i.entry;
  assign idle_hit    = since_comm >= {16'd0, cfg_i.idle_timeout};
  assign sleep_hit   = since_comm >= {16'd0, cfg_i.sleep_timeout};
  assign res_ok      = action_result_i == RES_OK;

  always_comb begin
    nxt      = cur_i;
    action_o = ACT_NONE;
    status_o = STAT_OK;
    comm_inc = 2'd0;
    crc_inc  = 1'b0;
    meas_inc = 1'b0;
    unique case (cur_i.svc)
      SVC_BOOT: begin
        nxt.configured = 1'b0;
        nxt.link       = LINK_IDLE;
        nxt.entry      = now_ms_i;
        nxt.svc        = SVC_WAKE;
      end
      SVC_WAKE: begin
        action_o = ACT_WAKE;
        if (!res_ok) begin
          comm_inc = 2'd1;
        end else begin
          nxt.link      = LINK_READY;
          nxt.last_comm = now_ms_i;
          nxt.entry     = now_ms_i;
          nxt.svc       = cur_i.configured ? SVC_START : SVC_CONFIG;
        end
      end
      SVC_CONFIG: begin
        action_o = ACT_CONFIG;
        if (!res_ok) begin
          comm_inc       = (action_result_i == RES_LINK) ? 2'd2 : 2'd1;
          crc_inc        = action_result_i == RES_CRC;
          nxt.configured = 1'b0;
        end else begin
          nxt.configured = 1'b1;
          nxt.link       = LINK_READY;
          nxt.last_comm  = now_ms_i;
          nxt.entry      = now_ms_i;
          nxt.svc        = SVC_START;
        end
      end
      SVC_STANDBY: begin
        if (since_meas >= cfg_i.measure_period) begin
          if (sleep_hit) begin
            nxt.configured = 1'b0;
            nxt.svc        = SVC_WAKE;
          end else if (idle_hit) begin
            nxt.svc = SVC_WAKE;
          end else begin
            nxt.svc = SVC_START;
          end
          nxt.entry = now_ms_i;
        end
      end
      SVC_START: begin
        if (sleep_hit) begin
          nxt.configured = 1'b0;
          nxt.svc        = SVC_WAKE;
        end else if (idle_hit) begin
          nxt.svc = SVC_WAKE;
        end else begin
          action_o = ACT_START;
          if (!res_ok) begin
            comm_inc = 2'd1;
          end else begin
            nxt.link      = LINK_XFER;
            nxt.last_comm = now_ms_i;
            nxt.entry     = now_ms_i;
            meas_inc      = 1'b1;
            nxt.svc       = SVC_WAIT;
          end
        end
      end
      SVC_WAIT: begin
        if (since_entry > {24'd0, cfg_i.conversion_time}) begin
          if (idle_hit && !res_ok) begin
            action_o = ACT_WAKE;
            comm_inc = 2'd1;
          end else begin
            if (idle_hit) begin
              action_o      = ACT_WAKE;
              nxt.last_comm = now_ms_i;
              nxt.link      = LINK_READY;
            end
            nxt.svc = SVC_READ;
          end
        end
      end
      SVC_READ: begin
        action_o = ACT_READ;
        if (!res_ok) begin
          comm_inc = 2'd1;
          crc_inc  = action_result_i == RES_CRC;
        end else begin
          nxt.link         = LINK_READY;
          nxt.last_comm    = now_ms_i;
          nxt.last_measure = now_ms_i;
          nxt.svc          = SVC_PROCESS;
        end
      end
      SVC_PROCESS: begin
        nxt.svc = SVC_STANDBY;
      end
      SVC_FAULT: begin
        nxt.configured = 1'b0;
        nxt.link       = LINK_ERROR;
        nxt.entry      = now_ms_i;
        nxt.svc        = SVC_WAKE;
      end
      default: begin
        nxt.configured = 1'b0;
        nxt.svc        = SVC_FAULT;
        status_o       = STAT_STATE_ERR;
      end
    endcase

    // Any counted communication error is a failure that ends in fault.
    if (comm_inc != 2'd0) begin
      nxt.link = LINK_ERROR;
      nxt.svc  = SVC_FAULT;
      status_o = STAT_COMM_ERR;
    end
    nxt.comm_errors  = cur_i.comm_errors + {{(CountW-2){1'b0}}, comm_inc};
    nxt.crc_errors   = cur_i.crc_errors + {{(CountW-1){1'b0}}, crc_inc};
    nxt.measurements = cur_i.measurements + {{(CountW-1){1'b0}}, meas_inc};
  end

  assign nxt_o = nxt;

endmodule

`default_nettype wire

/* design/cell_monitor_service_sequencer_top.sv */
// ----------------------------------------------------------------------------
// cell_monitor_service_sequencer_top
// Service sequencer for a battery-monitor stack, one service tick per item.
//
// Each input item on the s_axis channel is one service tick carrying the
// current millisecond time and the outcome of the action issued this tick.
// For every tick exactly one result item leaves on m_axis: the action, the
// status, the new service and link states, the configured flag and the three
// wrapping error and measurement counters.
// m_axis_tvalid rises in the cycle after acceptance, and one tick can be
// taken every clock: the whole step is a single pass of compare and add
// logic between the sequencer state registers and the result register.
// When the receiver stalls, the result register holds its item and
// s_axis_tready drops until that item is taken.
// Reset puts the sequencer in the boot state with the link off, clears all
// time stamps and counters, and loads the configuration defaults (period
// 100 ms, idle 5 ms, sleep 2000 ms, conversion 8 ms). Registers are written
// on the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_monitor_service_sequencer_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] now_ms, [33:32] action_result, [39:34] zero
  input  logic [39:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] action, [4:3] status, [8:5] service_state, [11:9] link_state,
  // [12] is_configured, [44:13] link_error_total, [76:45] crc_error_total,
  // [108:77] measure_total, [111:109] zero
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import cmss_pkg::*;

  cfg_t         cfg_q;
  seq_state_t   st_q;
  seq_state_t   st_d;
  action_e      action;
  status_e      status;
  logic         out_valid_q;
  logic [111:0] out_data_q;
  logic         in_fire;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.measure_period  <= MeasurePeriodRst;
      cfg_q.idle_timeout    <= IdleTimeoutRst;
      cfg_q.sleep_timeout   <= SleepTimeoutRst;
      cfg_q.conversion_time <= ConversionTimeRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MEASURE_PERIOD:  cfg_q.measure_period  <= cfg_data_i;
        REG_IDLE_TIMEOUT:    cfg_q.idle_timeout    <= cfg_data_i[15:0];
        REG_SLEEP_TIMEOUT:   cfg_q.sleep_timeout   <= cfg_data_i[15:0];
        REG_CONVERSION_TIME: cfg_q.conversion_time <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  cmss_step u_step (
    .cfg_i           (cfg_q),
    .cur_i           (st_q),
    .now_ms_i        (s_axis_tdata[31:0]),
    .action_result_i (s_axis_tdata[33:32]),
    .nxt_o           (st_d),
    .action_o        (action),
    .status_o        (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.svc          <= SVC_BOOT;
      st_q.link         <= LINK_OFF;
      st_q.configured   <= 1'b0;
      st_q.last_comm    <= '0;
      st_q.last_measure <= '0;
      st_q.entry        <= '0;
      st_q.comm_errors  <= '0;
      st_q.crc_errors   <= '0;
      st_q.measurements <= '0;
    end else if (in_fire) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {3'd0, st_d.measurements, st_d.crc_errors, st_d.comm_errors,
                     st_d.configured, st_d.link, st_d.svc, status, action};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
